// ----- hw/rtl/tlvd_pkg.sv -----
// tlvd_pkg: shared types, status codes and the known-type length table
// used by the element deframer modules; no dependencies
`default_nettype none

package tlvd_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BADLEN   = 3'd1;
  localparam status_t ST_MEAS_OK  = 3'd2;
  localparam status_t ST_MEAS_BAD = 3'd3;
  localparam status_t ST_UNKNOWN  = 3'd4;

  localparam int TableRows = 22;

  localparam logic [15:0] MEAS_TYPE_HI = 16'h0500;

  // known element types with their allowed body lengths
  localparam logic [15:0] TYPE_ID [TableRows] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0010, 16'h0011, 16'h0012,
    16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017, 16'h0018,
    16'h0020, 16'h0021, 16'h0022, 16'h0032, 16'h0034, 16'h0035,
    16'h0042, 16'h0100, 16'h0101, 16'h0300
  };
  localparam logic [7:0] TYPE_LO [TableRows] = '{
    8'd0, 8'd6, 8'd0, 8'd8, 8'd4, 8'd0,
    8'd3, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd4, 8'd1, 8'd1,
    8'd4, 8'd0, 8'd0, 8'd0
  };
  localparam logic [7:0] TYPE_HI [TableRows] = '{
    8'd2,   8'd8,   8'd10,  8'd11,  8'd4,   8'd127,
    8'd3,   8'd2,   8'd5,   8'd30,  8'd6,   8'd4,
    8'd127, 8'd127, 8'd127, 8'd6,   8'd4,   8'd8,
    8'd4,   8'd127, 8'd127, 8'd2
  };

  // one result item
  typedef struct packed {
    logic [15:0] element_type;
    logic [6:0]  element_length;
    logic [6:0]  body_offset;
    logic [7:0]  body_byte;
    logic        byte_present;
    status_t     status;
    logic        last_of_element;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlvd_classify.sv -----
// tlvd_classify: checks a completed element header against the known-type
// table and the measurement rules; uses tlvd_pkg
`default_nettype none

module tlvd_classify #(
  parameter int KNOWN_TYPE_COUNT = 22
) (
  input  wire logic [15:0]      elem_type,
  input  wire logic [6:0]       elem_len,
  input  wire logic [7:0]       max_unit,
  output tlvd_pkg::status_t     status
);
  import tlvd_pkg::*;

  logic [TableRows-1:0] match;
  logic [TableRows-1:0] bad_len;
  logic                 meas_len_ok;

  // all table rows compared in parallel
  always_comb begin
    for (int i = 0; i < TableRows; i++) begin
      match[i]   = (i < KNOWN_TYPE_COUNT) && (elem_type == TYPE_ID[i]);
      bad_len[i] = ({1'b0, elem_len} < TYPE_LO[i]) || ({1'b0, elem_len} > TYPE_HI[i]);
    end
  end

  assign meas_len_ok = (elem_len == 7'd1) || (elem_len == 7'd2) ||
                       (elem_len == 7'd4) || (elem_len == 7'd8);

  always_comb begin
    priority if (|match) begin
      status = (|(match & bad_len)) ? ST_BADLEN : ST_OK;
    end else if (elem_type[15:8] == MEAS_TYPE_HI[15:8]) begin
      if (elem_type[7:0] > max_unit) begin
        status = ST_MEAS_BAD;
      end else begin
        status = meas_len_ok ? ST_MEAS_OK : ST_MEAS_BAD;
      end
    end else begin
      status = ST_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tlvd_parser.sv -----
// tlvd_parser: header/body state machine, one byte per transfer, builds
// at most one result per byte; uses tlvd_pkg and tlvd_classify
`default_nettype none

module tlvd_parser #(
  parameter int KNOWN_TYPE_COUNT = 22
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  input  wire logic           packet_start,
  input  wire logic [7:0]     max_unit,
  output logic                res_valid,
  output tlvd_pkg::res_t      res
);
  import tlvd_pkg::*;

  localparam logic [1:0] PH_LEN     = 2'd0;
  localparam logic [1:0] PH_TYPE_A  = 2'd1;
  localparam logic [1:0] PH_TYPE_LO = 2'd2;
  localparam logic [1:0] PH_BODY    = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic        ext_r, ext_nxt;
  logic [15:0] type_r, type_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  left_r, left_nxt;
  status_t     stat_r, stat_nxt;

  logic [1:0]  phase;
  logic [6:0]  low;
  logic [15:0] hdr_type;
  status_t     hdr_status;
  logic        body_last;

  assign phase     = packet_start ? PH_LEN : phase_r;
  assign low       = data_byte[6:0];
  assign hdr_type  = (phase == PH_TYPE_LO) ? {type_r[15:8], data_byte} : {8'h00, data_byte};
  assign body_last = (left_r <= 7'd1);

  tlvd_classify #(
    .KNOWN_TYPE_COUNT(KNOWN_TYPE_COUNT)
  ) u_classify (
    .elem_type(hdr_type),
    .elem_len (len_r),
    .max_unit (max_unit),
    .status   (hdr_status)
  );

  always_comb begin
    phase_nxt = phase;
    ext_nxt   = ext_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    stat_nxt  = stat_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase)
      PH_LEN: begin
        type_nxt = '0;
        left_nxt = '0;
        stat_nxt = ST_OK;
        ext_nxt  = data_byte[7];
        if (low == 7'd0) begin
          // malformed: result on the length byte itself
          len_nxt             = '0;
          phase_nxt           = PH_LEN;
          res_valid           = 1'b1;
          res.status          = ST_UNKNOWN;
          res.last_of_element = 1'b1;
        end else if (data_byte[7] && (low == 7'd1)) begin
          // malformed extended header, reported on the next byte
          len_nxt   = '0;
          stat_nxt  = ST_UNKNOWN;
          phase_nxt = PH_TYPE_A;
        end else begin
          len_nxt   = data_byte[7] ? (low - 7'd2) : (low - 7'd1);
          phase_nxt = PH_TYPE_A;
        end
      end
      PH_TYPE_A, PH_TYPE_LO: begin
        if ((phase == PH_TYPE_A) && ext_r) begin
          type_nxt = {data_byte, 8'h00};
          if (stat_r == ST_UNKNOWN) begin
            phase_nxt           = PH_LEN;
            res_valid           = 1'b1;
            res.element_type    = {data_byte, 8'h00};
            res.status          = ST_UNKNOWN;
            res.last_of_element = 1'b1;
          end else begin
            phase_nxt = PH_TYPE_LO;
          end
        end else begin
          // header complete
          type_nxt = hdr_type;
          stat_nxt = hdr_status;
          if (len_r == 7'd0) begin
            phase_nxt           = PH_LEN;
            res_valid           = 1'b1;
            res.element_type    = hdr_type;
            res.status          = hdr_status;
            res.last_of_element = 1'b1;
          end else begin
            left_nxt  = len_r;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        res_valid           = 1'b1;
        res.element_type    = type_r;
        res.element_length  = len_r;
        res.body_offset     = len_r - left_r;
        res.body_byte       = data_byte;
        res.byte_present    = 1'b1;
        res.status          = stat_r;
        res.last_of_element = body_last;
        if (body_last) begin
          left_nxt  = '0;
          phase_nxt = PH_LEN;
        end else begin
          left_nxt = left_r - 7'd1;
        end
      end
      default: begin
        phase_nxt = PH_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      ext_r   <= 1'b0;
      type_r  <= '0;
      len_r   <= '0;
      left_r  <= '0;
      stat_r  <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      ext_r   <= ext_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      stat_r  <= stat_nxt;
    end
  end

`ifndef SYNTHESIS
  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (left_r != 7'd0))
    else $error("body phase with no bytes left");

  a_left_within_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (left_r <= len_r))
    else $error("bytes left exceeds element length");

  a_body_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !packet_start && (phase_r == PH_BODY)) |-> res_valid)
    else $error("body byte produced no result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/tlvd_out_buf.sv -----
// tlvd_out_buf: result register plus skid entry so the parser keeps taking
// bytes while a result waits; uses tlvd_pkg
`default_nettype none

module tlvd_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlvd_pkg::res_t push_res,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tlvd_pkg::res_t      out_res
);
  import tlvd_pkg::*;

  logic head_vld_r, head_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop       = head_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_res   = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        head_nxt     = push_res;
        head_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !push)
    else $error("result pushed into full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_vld_r) |=> (head_vld_r && (head_r == $past(skid_r))))
    else $error("skid entry lost on transfer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/tlv_element_deframer_top.sv -----
// timing: a result appears on the out_ port in the cycle after the transfer of the byte
//   causing it when the result register is free, later while out_stall holds earlier results
// throughput: one byte per cycle while in_stall is low; each byte yields zero or one result
//   via a result register plus skid entry, and in_stall rises only when both entries are held
// reset: synchronous active-low rst_n returns the parser to expecting a length byte,
//   empties the output buffer and sets the measurement unit limit to 28
`default_nettype none

module tlv_element_deframer_top #(
  parameter int KNOWN_TYPE_COUNT = 22
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_packet_start,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_element_type,
  output logic [6:0]       out_element_length,
  output logic [6:0]       out_body_offset,
  output logic [7:0]       out_body_byte,
  output logic             out_byte_present,
  output tlvd_pkg::status_t out_status,
  output logic             out_last_of_element
);
  import tlvd_pkg::*;

  localparam logic [7:0] MaxUnitReset = 8'd28;

  logic       [7:0] max_unit_r;
  logic             in_xfer;
  logic             res_valid;
  res_t             res;
  logic             buf_full;
  res_t             out_res;

  // measurement unit limit; the user must write it only while idle (not enforced by the block)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_unit_r <= MaxUnitReset;
    end else if (cfg_we) begin
      max_unit_r <= cfg_wdata;
    end
  end

  // stall is a registered flag, so valid and stall stay independent
  assign in_stall = buf_full;
  assign in_xfer  = in_valid && !in_stall;

  // parser: header decode, table check, body numbering
  tlvd_parser #(
    .KNOWN_TYPE_COUNT(KNOWN_TYPE_COUNT)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_xfer),
    .data_byte   (in_data_byte),
    .packet_start(in_packet_start),
    .max_unit    (max_unit_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register and skid
  tlvd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer && res_valid),
    .push_res (res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_element_type    = out_res.element_type;
  assign out_element_length  = out_res.element_length;
  assign out_body_offset     = out_res.body_offset;
  assign out_body_byte       = out_res.body_byte;
  assign out_byte_present    = out_res.byte_present;
  assign out_status          = out_res.status;
  assign out_last_of_element = out_res.last_of_element;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for tlv_element_deframer_top; a queue-fed byte driver,
// a randomly stalling result monitor and an in-bench element parser that predicts results
// depends on tlvd_pkg (status codes, res_t) and the deframer rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlvd_pkg::*;

  // known element types and their allowed body lengths, kept apart from the rtl copy
  localparam int NUM_KNOWN = 22;
  localparam logic [15:0] KNOWN_ID [NUM_KNOWN] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0010, 16'h0011, 16'h0012,
    16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017, 16'h0018,
    16'h0020, 16'h0021, 16'h0022, 16'h0032, 16'h0034, 16'h0035,
    16'h0042, 16'h0100, 16'h0101, 16'h0300
  };
  localparam logic [7:0] KNOWN_MIN [NUM_KNOWN] = '{
    8'd0, 8'd6, 8'd0, 8'd8, 8'd4, 8'd0, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd4, 8'd1, 8'd1, 8'd4, 8'd0, 8'd0, 8'd0
  };
  localparam logic [7:0] KNOWN_MAX [NUM_KNOWN] = '{
    8'd2, 8'd8, 8'd10, 8'd11, 8'd4, 8'd127, 8'd3, 8'd2, 8'd5, 8'd30, 8'd6,
    8'd4, 8'd127, 8'd127, 8'd127, 8'd6, 8'd4, 8'd8, 8'd4, 8'd127, 8'd127, 8'd2
  };

  // where the parser is inside the current element
  typedef enum logic [1:0] {
    EXPECT_LEN,
    EXPECT_TYPE,
    EXPECT_TYPE_LO,
    IN_BODY
  } parse_state_e;

  // one byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } raw_byte_t;

  // clock, reset and dut ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = 8'h00;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_packet_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [15:0]       out_element_type;
  logic [6:0]        out_element_length;
  logic [6:0]        out_body_offset;
  logic [7:0]        out_body_byte;
  logic              out_byte_present;
  status_t           out_status;
  logic              out_last_of_element;

  // bytes still to be sent and element results still to be seen
  raw_byte_t   tx_bytes[$];
  res_t        element_results[$];

  // parser model state, starting at its reset values
  parse_state_e parse_state = EXPECT_LEN;
  logic         wide_id = 1'b0;
  logic [15:0]  cur_type = 16'h0000;
  logic [6:0]   cur_len = 7'd0;
  logic [6:0]   body_left = 7'd0;
  status_t      cur_status = ST_OK;
  logic [7:0]   unit_limit = 8'd28;   // mirrors the dut measurement unit limit

  // bench bookkeeping
  logic        byte_taken = 1'b0;  // a byte transfer happened at the last rising edge
  logic        quiet = 1'b0;       // no gaps and no stalls while set
  int          send_gap = 0;
  int          stall_left = 0;
  int          phase_bytes = 0;
  int          err_count = 0;

  tlv_element_deframer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_packet_start     (in_packet_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_element_type    (out_element_type),
    .out_element_length  (out_element_length),
    .out_body_offset     (out_body_offset),
    .out_body_byte       (out_body_byte),
    .out_byte_present    (out_byte_present),
    .out_status          (out_status),
    .out_last_of_element (out_last_of_element)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // element parser model
  // ---------------------------------------------------------------------------

  // status of a completed header: table lookup first, then the measurement rule
  function automatic status_t length_check(logic [15:0] t, logic [6:0] len);
    for (int i = 0; i < NUM_KNOWN; i++) begin
      if (KNOWN_ID[i] == t) begin
        if ({1'b0, len} < KNOWN_MIN[i] || {1'b0, len} > KNOWN_MAX[i]) return ST_BADLEN;
        return ST_OK;
      end
    end
    if (t[15:8] == MEAS_TYPE_HI[15:8]) begin
      // low byte is the unit index; body must be a power of two up to eight
      if (t[7:0] > unit_limit) return ST_MEAS_BAD;
      if (len == 7'd1 || len == 7'd2 || len == 7'd4 || len == 7'd8) return ST_MEAS_OK;
      return ST_MEAS_BAD;
    end
    return ST_UNKNOWN;
  endfunction

  function automatic res_t mk_res(logic [15:0] t, logic [6:0] len, logic [6:0] off,
                                  logic [7:0] b, logic present, status_t st, logic is_last);
    res_t r;
    r.element_type    = t;
    r.element_length  = len;
    r.body_offset     = off;
    r.body_byte       = b;
    r.byte_present    = present;
    r.status          = st;
    r.last_of_element = is_last;
    return r;
  endfunction

  // advance the model by one transferred byte, queueing the result it causes if any
  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic hdr_done;
    logic is_last;
    hdr_done = 1'b0;
    if (start) parse_state = EXPECT_LEN;
    case (parse_state)
      EXPECT_LEN: begin
        cur_type   = 16'h0000;
        body_left  = 7'd0;
        cur_status = ST_OK;
        cur_len    = 7'd0;
        wide_id    = b[7];
        if (b[6:0] == 7'd0) begin
          // zero length in either form: malformed, answered on this byte
          element_results.push_back(mk_res(16'h0000, 7'd0, 7'd0, 8'h00, 1'b0,
                                           ST_UNKNOWN, 1'b1));
        end else if (b[7] && b[6:0] == 7'd1) begin
          // long form with room for only one type byte: malformed, answered on it
          cur_status  = ST_UNKNOWN;
          parse_state = EXPECT_TYPE;
        end else begin
          cur_len     = b[7] ? b[6:0] - 7'd2 : b[6:0] - 7'd1;
          parse_state = EXPECT_TYPE;
        end
      end
      EXPECT_TYPE: begin
        if (wide_id) begin
          cur_type = {b, 8'h00};
          if (cur_status == ST_UNKNOWN) begin
            parse_state = EXPECT_LEN;
            element_results.push_back(mk_res(cur_type, 7'd0, 7'd0, 8'h00, 1'b0,
                                             ST_UNKNOWN, 1'b1));
          end else begin
            parse_state = EXPECT_TYPE_LO;
          end
        end else begin
          cur_type = {8'h00, b};
          hdr_done = 1'b1;
        end
      end
      EXPECT_TYPE_LO: begin
        cur_type[7:0] = b;
        hdr_done      = 1'b1;
      end
      default: begin
        is_last = (body_left <= 7'd1);
        element_results.push_back(mk_res(cur_type, cur_len, cur_len - body_left, b, 1'b1,
                                         cur_status, is_last));
        if (is_last) begin
          body_left   = 7'd0;
          parse_state = EXPECT_LEN;
        end else begin
          body_left = body_left - 7'd1;
        end
      end
    endcase
    if (hdr_done) begin
      cur_status = length_check(cur_type, cur_len);
      if (cur_len == 7'd0) begin
        // empty body: a single result carrying no byte
        parse_state = EXPECT_LEN;
        element_results.push_back(mk_res(cur_type, 7'd0, 7'd0, 8'h00, 1'b0,
                                         cur_status, 1'b1));
      end else begin
        body_left   = cur_len;
        parse_state = IN_BODY;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver, receiver stall and monitor
  // ---------------------------------------------------------------------------

  // idle length: mostly none, often short, now and then a long one
  function automatic int draw_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // byte driver: holds a byte until its transfer, then waits out its gap before the next
  always @(negedge clk) begin : byte_driver
    raw_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() > 0) begin
        nxt = tx_bytes.pop_front();
        in_valid        <= 1'b1;
        in_data_byte    <= nxt.data;
        in_packet_start <= nxt.start;
        send_gap = quiet ? 0 : draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = quiet ? 0 : draw_gap();
    end
  end

  function automatic void cmp_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
      err_count++;
    end
  endfunction

  // monitor: check the result transfer first, then predict from the byte transfer;
  // a byte's result never shows up on the edge that moved the byte
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (element_results.size() == 0) begin
          $display("%0t: result with nothing expected, type %h offset %0d byte %h",
                   $time, out_element_type, out_body_offset, out_body_byte);
          err_count++;
        end else begin
          want = element_results.pop_front();
          cmp_field("element_type", want.element_type, out_element_type);
          cmp_field("element_length", 16'(want.element_length), 16'(out_element_length));
          cmp_field("body_offset", 16'(want.body_offset), 16'(out_body_offset));
          cmp_field("body_byte", 16'(want.body_byte), 16'(out_body_byte));
          cmp_field("byte_present", 16'(want.byte_present), 16'(out_byte_present));
          cmp_field("status", 16'(want.status), 16'(out_status));
          cmp_field("last_of_element", 16'(want.last_of_element), 16'(out_last_of_element));
        end
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_packet_start);
      byte_taken <= in_valid && !in_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic send(input logic [7:0] b, input logic st);
    raw_byte_t x;
    x.data  = b;
    x.start = st;
    tx_bytes.push_back(x);
    phase_bytes++;
  endtask

  // body length near the table bounds, or small and legal
  function automatic int pick_len(int lo, int hi);
    if (hi >= 126) hi = 9;  // open-ended rows: keep bodies short
    case ($urandom_range(0, 4))
      0: return (lo > 0) ? lo - 1 : lo;
      1: return lo;
      2: return hi;
      3: return hi + 1;
      default: return int'($urandom_range(lo, (hi < lo + 6) ? hi : lo + 6));
    endcase
  endfunction

  // one element with random content; cut drops part of the body so a restart breaks in
  task automatic gen_element(input bit first, input bit cut);
    int kind;
    int n;
    int len;
    logic [15:0] t;
    logic wide;
    logic [7:0] unit;
    kind = int'($urandom_range(0, 99));
    if (kind < 5) begin
      // malformed headers
      case ($urandom_range(0, 2))
        0: send(8'h00, first);
        1: send(8'h80, first);
        default: begin
          send(8'h81, first);
          send(8'($urandom), 1'b0);
        end
      endcase
      return;
    end
    if (kind < 50) begin
      n    = int'($urandom_range(0, NUM_KNOWN - 1));
      t    = KNOWN_ID[n];
      wide = (t[15:8] != 8'h00) || ($urandom_range(0, 3) == 0);
      len  = pick_len(int'(KNOWN_MIN[n]), int'(KNOWN_MAX[n]));
    end else if (kind < 75) begin
      // measurement: unit at, just past or far from the limit
      wide = 1'b1;
      case ($urandom_range(0, 4))
        0: unit = unit_limit;
        1: unit = unit_limit + 8'd1;
        2: unit = 8'h00;
        3: unit = 8'hff;
        default: unit = 8'($urandom);
      endcase
      t = {MEAS_TYPE_HI[15:8], unit};
      if ($urandom_range(0, 9) < 7) len = 1 << $urandom_range(0, 3);
      else len = int'($urandom_range(0, 12));
    end else begin
      wide = ($urandom_range(0, 1) == 1);
      t    = wide ? 16'($urandom) : {8'h00, 8'($urandom)};
      len  = int'($urandom_range(0, 10));
    end
    // the odd element with a body near the maximum
    if ($urandom_range(0, 99) < 2) len = int'($urandom_range(100, 126));
    if (len > 126) len = 126;
    if (wide && len > 125) len = 125;
    if (wide) begin
      send(8'h80 | 8'(len + 2), first);
      send(t[15:8], 1'b0);
      send(t[7:0], 1'b0);
    end else begin
      send(8'(len + 1), first);
      send(t[7:0], 1'b0);
    end
    if (cut && len > 0) len = int'($urandom_range(0, len - 1));
    repeat (len) send(8'($urandom), 1'b0);
  endtask

  // a packet: start flag on its first byte, elements back to back after it
  task automatic gen_packet();
    int n;
    n = int'($urandom_range(1, 4));
    for (int k = 0; k < n; k++)
      gen_element(k == 0, (k == n - 1) && ($urandom_range(0, 9) == 0));
  endtask

  // mostly well-formed packets, some loose random bytes
  task automatic gen_phase(input int target);
    phase_bytes = 0;
    while (phase_bytes < target) begin
      if ($urandom_range(0, 9) < 9) begin
        gen_packet();
      end else begin
        repeat ($urandom_range(1, 6)) send(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // returns at a rising edge once every byte is sent and every result seen
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || element_results.size() != 0) @(posedge clk);
  endtask

  // register write while idle; a wait before it covers a header byte still in flight
  task automatic set_unit_limit(input logic [7:0] v);
    repeat (3) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    unit_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the reset unit limit of 28
    send(8'h00, 1'b1);                                        // zero short length
    send(8'h80, 1'b0);                                        // zero long length
    send(8'h81, 1'b0); send(8'ha5, 1'b0);                     // long form, one type byte
    send(8'h01, 1'b0); send(8'h00, 1'b0);                     // type 0, empty body
    send(8'h03, 1'b0); send(8'h14, 1'b0);                     // exact-length type
    send(8'hff, 1'b0); send(8'h00, 1'b0);
    send(8'h84, 1'b0); send(8'h05, 1'b0); send(8'd28, 1'b0);  // unit right at the limit
    send(8'h5a, 1'b0); send(8'ha5, 1'b0);
    send(8'h83, 1'b0); send(8'h05, 1'b0); send(8'd29, 1'b0);  // unit one past the limit
    send(8'h7f, 1'b0);
    send(8'h02, 1'b0); send(8'h99, 1'b0); send(8'h80, 1'b0);  // unknown type passes body
    send(8'h04, 1'b0); send(8'h12, 1'b0); send(8'h11, 1'b0);  // body cut by a restart
    send(8'h01, 1'b1); send(8'h42, 1'b0);                     // empty body, too short
    wait_idle();

    // random part across the register extremes
    set_unit_limit(8'd0);
    gen_phase(210);
    wait_idle();

    set_unit_limit(8'd255);
    quiet = 1'b1;
    gen_phase(210);
    wait_idle();
    quiet = 1'b0;

    // sender holds off mid-phase until every result is back
    set_unit_limit(8'($urandom));
    gen_phase(110);
    wait_idle();
    gen_phase(110);
    wait_idle();

    set_unit_limit(8'd28);
    gen_phase(210);
    wait_idle();

    repeat (8) @(posedge clk);
    if (err_count == 0 && element_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tlvd_pkg.sv
hw/rtl/tlvd_classify.sv
hw/rtl/tlvd_parser.sv
hw/rtl/tlvd_out_buf.sv
hw/rtl/tlv_element_deframer_top.sv
tb/sv/testbench.sv
